### design/xeu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_pkg: shared types and constants of the XML entity unescaper
// Character codes, the named entity table and the command passed from the
// classifying front end to the emitting back end.
// ----------------------------------------------------------------------------
package xeu_pkg;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD    = 2'd1;
	localparam logic [1:0] ST_NOSEMI = 2'd2;

	localparam int NUM_ENT   = 4;
	localparam int ENT_MAX   = 6;
	localparam int PEND_DEPTH = 5;
	localparam int MAX_RES   = 6;

	// &lt; &gt; &quot; &amp;, padded with zero bytes
	localparam logic [0:NUM_ENT-1][0:ENT_MAX-1][7:0] ENT_TEXT = '{
		'{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
		'{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00}
	};
	localparam logic [0:NUM_ENT-1][2:0] ENT_LEN = '{3'd4, 3'd4, 3'd6, 3'd5};
	localparam logic [0:NUM_ENT-1][7:0] ENT_CHAR = '{8'h3C, 8'h3E, 8'h22, 8'h26};

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Results of one input: data[0..nres-1]; all but the last are plain bytes.
	typedef struct packed {
		logic [2:0]               nres;
		logic [0:MAX_RES-1][7:0]  data;
		logic                     tail_valid;
		logic [1:0]               tail_status;
		logic                     text_end;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

endpackage

### design/xeu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_front: byte classifier
// Tracks partial entity matches and numeric references, and turns each input
// byte that causes results into one command listing them.
// ----------------------------------------------------------------------------
module xeu_front import xeu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       text_last,
	input  logic       q_full,
	output cmd_chan_t  push
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_NAMED = 2'd1;
	localparam logic [1:0] PH_NUM   = 2'd2;

	logic [1:0] phase_q, nxt_phase;
	logic [0:PEND_DEPTH-1][7:0] pend_q, nxt_pend;
	logic [2:0] pcnt_q, nxt_pcnt;
	logic [7:0] cval_q, nxt_cval;
	logic [1:0] dcnt_q, nxt_dcnt;
	logic       err_q, nxt_err;

	logic [0:MAX_RES-1][7:0] data;
	logic [2:0] n;
	logic       tail_valid;
	logic [1:0] tail_status;
	logic       tend;
	logic       do_idle;
	logic       is_digit;
	logic       pre_ok;
	logic       hit_done;
	logic       hit_more;
	logic [7:0] done_char;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		nxt_phase   = phase_q;
		nxt_pend    = pend_q;
		nxt_pcnt    = pcnt_q;
		nxt_cval    = cval_q;
		nxt_dcnt    = dcnt_q;
		nxt_err     = err_q;
		data        = '0;
		n           = 3'd0;
		tail_valid  = 1'b1;
		tail_status = ST_OK;
		tend        = 1'b0;
		do_idle     = 1'b0;
		pre_ok      = 1'b0;
		hit_done    = 1'b0;
		hit_more    = 1'b0;
		done_char   = '0;
		is_digit    = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);

		if (!err_q) begin
			unique case (phase_q)
				PH_NUM: begin
					if (in_byte == CH_SEMI) begin
						data[0]   = cval_q;
						n         = 3'd1;
						nxt_phase = PH_IDLE;
					end else if (is_digit && dcnt_q != 2'd3) begin
						nxt_cval = (cval_q << 3) + (cval_q << 1) + (in_byte - CH_ZERO);
						nxt_dcnt = dcnt_q + 2'd1;
					end else begin
						data[0]     = '0;
						n           = 3'd1;
						tail_valid  = 1'b0;
						tail_status = ST_BAD;
						nxt_err     = 1'b1;
						nxt_phase   = PH_IDLE;
						nxt_pcnt    = 3'd0;
					end
				end
				PH_NAMED: begin
					if (pcnt_q == 3'd1 && in_byte == CH_HASH) begin
						nxt_pcnt  = 3'd0;
						nxt_phase = PH_NUM;
						nxt_cval  = '0;
						nxt_dcnt  = '0;
					end else begin
						for (int p = 0; p < NUM_ENT; p++) begin
							pre_ok = 1'b1;
							for (int i = 0; i < PEND_DEPTH; i++) begin
								if (3'(i) < pcnt_q && pend_q[i] != ENT_TEXT[p][i])
									pre_ok = 1'b0;
							end
							if (pre_ok && ENT_LEN[p] > pcnt_q
									&& ENT_TEXT[p][pcnt_q] == in_byte) begin
								if (ENT_LEN[p] == 3'(pcnt_q + 3'd1)) begin
									hit_done  = 1'b1;
									done_char = ENT_CHAR[p];
								end else begin
									hit_more = 1'b1;
								end
							end
						end
						if (hit_done) begin
							data[0]   = done_char;
							n         = 3'd1;
							nxt_pcnt  = 3'd0;
							nxt_phase = PH_IDLE;
						end else if (hit_more && pcnt_q < 3'(PEND_DEPTH)) begin
							nxt_pend[pcnt_q] = in_byte;
							nxt_pcnt         = pcnt_q + 3'd1;
						end else begin
							// flush the held bytes, then treat this byte afresh
							for (int j = 0; j < PEND_DEPTH; j++) begin
								if (3'(j) < pcnt_q)
									data[j] = pend_q[j];
							end
							n         = pcnt_q;
							nxt_pcnt  = 3'd0;
							nxt_phase = PH_IDLE;
							do_idle   = 1'b1;
						end
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase

			if (do_idle) begin
				if (in_byte == CH_AMP) begin
					nxt_pend[0] = CH_AMP;
					nxt_pcnt    = 3'd1;
					nxt_phase   = PH_NAMED;
				end else begin
					data[n] = in_byte;
					n       = n + 3'd1;
				end
			end
		end

		if (text_last) begin
			if (!nxt_err) begin
				if (nxt_phase == PH_NAMED) begin
					// a match left open at the end is plain text
					if (n == 3'd0) begin
						for (int j = 0; j < PEND_DEPTH; j++) begin
							if (3'(j) < nxt_pcnt)
								data[j] = nxt_pend[j];
						end
						n = nxt_pcnt;
					end else begin
						data[n] = CH_AMP;
						n       = n + 3'd1;
					end
				end else if (nxt_phase == PH_NUM) begin
					data[n]     = '0;
					n           = n + 3'd1;
					tail_valid  = 1'b0;
					tail_status = ST_NOSEMI;
				end
			end
			if (n == 3'd0) begin
				tail_valid = 1'b0;
				n          = 3'd1;
			end
			tend      = 1'b1;
			nxt_phase = PH_IDLE;
			nxt_pcnt  = 3'd0;
			nxt_cval  = '0;
			nxt_dcnt  = '0;
			nxt_err   = 1'b0;
		end
	end

	always_comb begin
		push.valid            = accept && (n != 3'd0);
		push.cmd.nres         = n;
		push.cmd.data         = data;
		push.cmd.tail_valid   = tail_valid;
		push.cmd.tail_status  = tail_status;
		push.cmd.text_end     = tend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pcnt_q  <= '0;
			cval_q  <= '0;
			dcnt_q  <= '0;
			err_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= nxt_phase;
			pcnt_q  <= nxt_pcnt;
			cval_q  <= nxt_cval;
			dcnt_q  <= nxt_dcnt;
			err_q   <= nxt_err;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			pend_q <= nxt_pend;
	end

	a_pcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= 3'(PEND_DEPTH))
		else $error("held byte count beyond buffer");

	a_num_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_NUM || err_q) |-> pcnt_q == 3'd0)
		else $error("held bytes while not in a named match");

endmodule

### design/xeu_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_cmdq: command queue
// Short FIFO between the classifier and the emitter.
// ----------------------------------------------------------------------------
module xeu_cmdq import xeu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_chan_t push,
	output logic      full,
	output cmd_chan_t head,
	input  logic      pop
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = cnt_q == QCNT_W'(QDEPTH);
	assign head.valid = cnt_q != '0;
	assign head.cmd   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push.valid)
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push.valid && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push.valid)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wptr_q] <= push.cmd;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("command written into a full queue");

endmodule

### design/xeu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xeu_back: result emitter
// Walks the head command one result per cycle, when not stalled, into the output register.
// ----------------------------------------------------------------------------
module xeu_back import xeu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_chan_t  head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       text_end,
	output logic [1:0] status
);

	logic [2:0] idx_q;
	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       obvalid_q;
	logic       orl_q;
	logic       ote_q;
	logic [1:0] ost_q;
	logic       load;
	logic       is_tail;

	assign load    = head.valid && (!ovalid_q || out_ready);
	assign is_tail = idx_q == 3'(head.cmd.nres - 3'd1);
	assign pop     = load && is_tail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (load)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
			if (load)
				idx_q <= is_tail ? 3'd0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (is_tail) begin
				obyte_q   <= head.cmd.tail_valid ? head.cmd.data[idx_q] : 8'd0;
				obvalid_q <= head.cmd.tail_valid;
				orl_q     <= 1'b1;
				ote_q     <= head.cmd.text_end;
				ost_q     <= head.cmd.tail_status;
			end else begin
				obyte_q   <= head.cmd.data[idx_q];
				obvalid_q <= 1'b1;
				orl_q     <= 1'b0;
				ote_q     <= 1'b0;
				ost_q     <= ST_OK;
			end
		end
	end

	assign out_valid  = ovalid_q;
	assign out_byte   = obyte_q;
	assign byte_valid = obvalid_q;
	assign run_last   = orl_q;
	assign text_end   = ote_q;
	assign status     = ost_q;

	a_idx_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd0 |-> head.valid)
		else $error("emitter mid-command with empty queue");

endmodule

### design/xml_entity_unescaper_core.sv
// Path: a byte's command is queued, then its results enter the output register.
// Throughput: one input byte per cycle while each byte gives one result; a byte
//   with more results holds the emitter for each of them, and input stalls once
//   the two-entry command queue is full.
// Reset: arst_n clears decode state, queue pointers and output valid at once; held
//   entity bytes are not cleared and are only read after being written.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_unescaper_core: streaming XML entity decoder
// Classifier front end, command queue and result emitter.
// ----------------------------------------------------------------------------
module xml_entity_unescaper_core import xeu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       text_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       text_end,
	output logic [1:0] status
);

	cmd_chan_t push;
	cmd_chan_t head;
	logic      q_full;
	logic      pop;

	xeu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.text_last (text_last),
		.q_full    (q_full),
		.push      (push)
	);

	xeu_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	xeu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.text_end   (text_end),
		.status     (status)
	);

endmodule

### test/xml_entity_unescaper_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_unescaper_core_tb: self-checking bench for the entity decoder
// Drives encoded texts byte by byte and decodes the same bytes alongside the
// block. Every byte it emits is checked against the decoded byte, flags and
// status expected for it. Random stalls are applied on both channels.
// ----------------------------------------------------------------------------
module xml_entity_unescaper_core_tb;
	import xeu_pkg::*;

	localparam int WATCHDOG_CYCLES = 5000;
	localparam int DRAIN_CYCLES    = 10;
	localparam int TARGET_BYTES    = 260;

	typedef enum logic [1:0] {PH_IDLE, PH_NAMED, PH_NUM} dec_phase_e;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} raw_byte_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       run_last;
		logic       text_end;
		logic [1:0] status;
	} decoded_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       text_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       text_end;
	logic [1:0] status;

	raw_byte_t  raw_q[$];
	logic [7:0] text_buf[$];
	decoded_t   step_q[$];
	decoded_t   decoded_q[$];

	int   send_idle_pct = 18;
	int   recv_idle_pct = 81;
	int   n_queued = 0;
	int   n_accepted = 0;
	int   mismatch_count = 0;
	int   quiet_cycles = 0;
	logic in_taken = 1'b0;

	// decoder state
	logic [7:0] held [0:PEND_DEPTH-1];
	int         held_cnt = 0;
	dec_phase_e dec_phase = PH_IDLE;
	logic [7:0] num_val = 8'h00;
	int         num_digits = 0;
	logic       err_seen = 1'b0;

	xml_entity_unescaper_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.text_last  (text_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.text_end   (text_end),
		.status     (status)
	);

	always #1 clk = ~clk;

	function automatic void named_entity(input int p, output logic [0:5][7:0] txt,
			output int len, output logic [7:0] ch);
		case (p)
			0: begin
				txt = {"&lt;", 16'h0000};
				len = 4;
				ch = "<";
			end
			1: begin
				txt = {"&gt;", 16'h0000};
				len = 4;
				ch = ">";
			end
			2: begin
				txt = "&quot;";
				len = 6;
				ch = 8'h22;
			end
			default: begin
				txt = {"&amp;", 8'h00};
				len = 5;
				ch = CH_AMP;
			end
		endcase
	endfunction

	function automatic void put(input logic [7:0] b, input logic v, input logic [1:0] st);
		decoded_t r;
		if (step_q.size() < MAX_RES) begin
			r.data = v ? b : 8'h00;
			r.valid = v;
			r.run_last = 1'b0;
			r.text_end = 1'b0;
			r.status = st;
			step_q.push_back(r);
		end
	endfunction

	function automatic void flush_held();
		for (int i = 0; i < held_cnt && i < PEND_DEPTH; i++)
			put(held[i], 1'b1, ST_OK);
		held_cnt = 0;
		dec_phase = PH_IDLE;
	endfunction

	function automatic void plain_byte(input logic [7:0] b);
		if (b == CH_AMP) begin
			held[0] = b;
			held_cnt = 1;
			dec_phase = PH_NAMED;
		end else begin
			put(b, 1'b1, ST_OK);
		end
	endfunction

	function automatic void flag_error(input logic [1:0] st);
		put(8'h00, 1'b0, st);
		err_seen = 1'b1;
		dec_phase = PH_IDLE;
		held_cnt = 0;
	endfunction

	// Decode one accepted byte and queue the bytes the block must emit for it.
	function automatic void decode_byte(input logic [7:0] b, input logic last);
		int                done;
		logic [7:0]        done_ch;
		logic              more;
		logic              hit;
		int                cnt;
		int                len;
		logic [0:5][7:0]   txt;
		logic [7:0]        ch;
		step_q.delete();
		if (err_seen) begin
			// swallow the rest of the text
		end else if (dec_phase == PH_NUM) begin
			if (b == CH_SEMI) begin
				put(num_val, 1'b1, ST_OK);
				dec_phase = PH_IDLE;
			end else if (b >= CH_ZERO && b <= CH_NINE && num_digits < 3) begin
				num_val = num_val * 8'd10 + (b - CH_ZERO);
				num_digits++;
			end else begin
				flag_error(ST_BAD);
			end
		end else if (dec_phase == PH_NAMED) begin
			cnt = held_cnt;
			if (cnt == 1 && b == CH_HASH) begin
				held_cnt = 0;
				dec_phase = PH_NUM;
				num_val = 8'h00;
				num_digits = 0;
			end else begin
				done = -1;
				done_ch = 8'h00;
				more = 1'b0;
				for (int p = 0; p < NUM_ENT; p++) begin
					named_entity(p, txt, len, ch);
					hit = (len >= cnt + 1) && (txt[cnt] == b);
					for (int i = 0; i < cnt; i++)
						if (txt[i] != held[i])
							hit = 1'b0;
					if (hit) begin
						if (len == cnt + 1) begin
							done = p;
							done_ch = ch;
						end else begin
							more = 1'b1;
						end
					end
				end
				if (done >= 0) begin
					put(done_ch, 1'b1, ST_OK);
					held_cnt = 0;
					dec_phase = PH_IDLE;
				end else if (more && cnt < PEND_DEPTH) begin
					held[cnt] = b;
					held_cnt = cnt + 1;
				end else begin
					// failed match: release the held bytes, then restart on this one
					flush_held();
					plain_byte(b);
				end
			end
		end else begin
			plain_byte(b);
		end

		if (last) begin
			if (!err_seen) begin
				if (dec_phase == PH_NAMED)
					flush_held();
				else if (dec_phase == PH_NUM)
					flag_error(ST_NOSEMI);
			end
			if (step_q.size() == 0)
				put(8'h00, 1'b0, ST_OK);
			step_q[step_q.size() - 1].text_end = 1'b1;
			held_cnt = 0;
			dec_phase = PH_IDLE;
			num_val = 8'h00;
			num_digits = 0;
			err_seen = 1'b0;
		end
		if (step_q.size() > 0)
			step_q[step_q.size() - 1].run_last = 1'b1;
		foreach (step_q[i])
			decoded_q.push_back(step_q[i]);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic void add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endfunction

	function automatic void commit_text();
		raw_byte_t it;
		for (int i = 0; i < text_buf.size(); i++) begin
			it.b = text_buf[i];
			it.last = (i == text_buf.size() - 1);
			raw_q.push_back(it);
			n_queued++;
		end
		text_buf.delete();
	endfunction

	function automatic void add_digits(input int n);
		for (int i = 0; i < n; i++)
			text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void add_entity(input int p, input int n);
		logic [0:5][7:0] txt;
		int              len;
		logic [7:0]      ch;
		named_entity(p, txt, len, ch);
		if (n > len)
			n = len;
		for (int i = 0; i < n; i++)
			text_buf.push_back(txt[i]);
	endfunction

	// Mostly well-formed references with random content, plus noise.
	function automatic void add_fragment();
		int p;
		p = $urandom_range(0, 3);
		case ($urandom_range(0, 9))
			0: add_entity(p, 6);
			1: add_entity(p, $urandom_range(1, 5));
			2, 3: begin
				add_str("&#");
				add_digits($urandom_range(0, 3));
				text_buf.push_back(CH_SEMI);
			end
			4: begin
				add_str("&#");
				add_digits($urandom_range(1, 4));
				if ($urandom_range(0, 1))
					text_buf.push_back(8'($urandom_range(0, 255)));
			end
			5, 6: text_buf.push_back(8'($urandom_range(0, 255)));
			7: text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
			8: begin
				case ($urandom_range(0, 3))
					0: text_buf.push_back(CH_AMP);
					1: text_buf.push_back(CH_HASH);
					2: text_buf.push_back(CH_SEMI);
					default: add_digits(1);
				endcase
			end
			default: begin
				if ($urandom_range(0, 1))
					add_str("&amp;");
				else
					add_str("&#38;");
				add_entity(p, 6);
			end
		endcase
	endfunction

	function automatic void add_random_text();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			add_fragment();
		commit_text();
	endfunction

	task automatic wait_idle();
		while (n_accepted != n_queued || decoded_q.size() != 0)
			@(negedge clk);
	endtask

	// Sender: hold the payload until the transfer, then pull the next byte.
	always @(negedge clk) begin : drive
		raw_byte_t it;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (raw_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					it = raw_q.pop_front();
					in_byte <= it.b;
					text_last <= it.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : watch
		decoded_t want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				decode_byte(in_byte, text_last);
				n_accepted++;
			end
			if (out_valid && out_ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected output, expected none, actual byte %0h",
						$time, out_byte);
					mismatch_count++;
				end else begin
					want = decoded_q.pop_front();
					check_field("out_byte", want.data, out_byte);
					check_field("byte_valid", want.valid, byte_valid);
					check_field("run_last", want.run_last, run_last);
					check_field("text_end", want.text_end, text_end);
					check_field("status", want.status, status);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// extremes, numeric value, then missing semicolon at the end
		text_buf.push_back(8'h00);
		text_buf.push_back(8'hFF);
		add_str("&#38;&#12");
		commit_text();
		// broken named match, full match, held match at the end of text
		add_str("&lt&gt;&am");
		commit_text();
		// fourth digit is an error; the byte after it only closes the text
		add_str("&#1234z");
		commit_text();

		while (n_queued < TARGET_BYTES / 3)
			add_random_text();
		wait_idle();

		send_idle_pct = 81;
		recv_idle_pct = 18;
		while (n_queued < 2 * TARGET_BYTES / 3)
			add_random_text();
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (n_queued < TARGET_BYTES)
			add_random_text();
		wait_idle();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && decoded_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
